// ===== rtl/tcc_pkg.sv =====
// Package with the thermocouple tables, widths, side-data types and segment search functions.
`default_nettype none
package tcc_pkg;

    localparam int DEG_SCALE = 1000;
    localparam int OUT_MIN   = -400000;
    localparam int OUT_MAX   = 1600000;
    localparam int J_POINTS  = 16;
    localparam int K_POINTS  = 20;

    localparam int FWD_NUM_W = 35;
    localparam int FWD_DEN_W = 17;
    localparam int FWD_QUO_W = 20;
    localparam int INV_NUM_W = 41;
    localparam int INV_DEN_W = 13;
    localparam int INV_QUO_W = 26;

    localparam int J_DEG [J_POINTS] = '{
        -200, -150, -100, -50, 0, 50, 100, 150,
        200, 250, 300, 400, 500, 600, 700, 800
    };
    localparam int J_UV [J_POINTS] = '{
        -7890, -6500, -4633, -2431, 0, 2585, 5269, 8010,
        10779, 13555, 16327, 21848, 27393, 33102, 39132, 45494
    };
    localparam int K_DEG [K_POINTS] = '{
        -200, -100, -50, 0, 50, 100, 150, 200, 300, 400,
        500, 600, 700, 800, 900, 1000, 1100, 1200, 1300, 1370
    };
    localparam int K_UV [K_POINTS] = '{
        -5891, -3554, -1889, 0, 2023, 4096, 6138, 8138, 12209, 16397,
        20644, 24905, 29129, 33275, 37326, 41276, 45119, 48838, 52410, 54819
    };

    typedef struct packed {
        logic signed [16:0] y1;
        logic signed [17:0] uv;
        logic               k_type;
    } fwd_side_t;

    typedef struct packed {
        logic signed [21:0] t1;
    } inv_side_t;

    function automatic int tcc_deg(logic k_type, logic [4:0] idx);
        return k_type ? K_DEG[idx] : J_DEG[idx[3:0]];
    endfunction

    function automatic int tcc_uv(logic k_type, logic [4:0] idx);
        return k_type ? K_UV[idx] : J_UV[idx[3:0]];
    endfunction

    function automatic logic [4:0] tcc_clamp(logic k_type, logic [4:0] idx);
        int n;
        logic [4:0] res;
        n = k_type ? K_POINTS : J_POINTS;
        res = idx;
        if (res == 5'd0)
            res = 5'd1;
        if (int'(res) >= n)
            res = 5'(n - 1);
        return res;
    endfunction

    // Truncated key cold/1000 is below T exactly when cold is below these bounds.
    function automatic logic [4:0] tcc_fwd_seg(logic k_type, logic signed [18:0] cold);
        int n;
        int deg;
        int thr;
        logic [4:0] idx;
        n = k_type ? K_POINTS : J_POINTS;
        idx = 5'd0;
        for (int k = 0; k < K_POINTS; k++)
        begin
            if (k < n)
            begin
                deg = tcc_deg(k_type, 5'(k));
                thr = (deg > 0) ? deg * DEG_SCALE : deg * DEG_SCALE - (DEG_SCALE - 1);
                if (int'(cold) >= thr)
                    idx = 5'(k + 1);
            end
        end
        return tcc_clamp(k_type, idx);
    endfunction

    function automatic logic [4:0] tcc_inv_seg(logic k_type, logic signed [22:0] uv);
        int n;
        logic [4:0] idx;
        n = k_type ? K_POINTS : J_POINTS;
        idx = 5'd0;
        for (int k = 0; k < K_POINTS; k++)
        begin
            if (k < n)
            begin
                if (int'(uv) >= tcc_uv(k_type, 5'(k)))
                    idx = 5'(k + 1);
            end
        end
        return tcc_clamp(k_type, idx);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tcc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sign and side data.
`default_nettype none
module tcc_div #(
    parameter int NUM_W  = tcc_pkg::FWD_NUM_W,
    parameter int DEN_W  = tcc_pkg::FWD_DEN_W,
    parameter int QUO_W  = tcc_pkg::FWD_QUO_W,
    parameter int SIDE_W = 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [NUM_W-1:0]    num_mag,
    input  wire logic [DEN_W-1:0]    den,
    input  wire logic                neg,
    input  wire logic [SIDE_W-1:0]   side_in,
    output logic                     out_valid,
    output logic signed [QUO_W:0]    quo,
    output logic [SIDE_W-1:0]        side_out
);
    import tcc_pkg::*;

    localparam int WORK_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [QUO_W:0]      valid_reg;
    logic [WORK_W-1:0]   rem_reg  [0:QUO_W-1];
    logic [DEN_W-1:0]    den_reg  [0:QUO_W-1];
    logic [QUO_W-1:0]    quo_reg  [0:QUO_W];
    logic                neg_reg  [0:QUO_W];
    logic [SIDE_W-1:0]   side_reg [0:QUO_W];
    logic [WORK_W-1:0]   rem_next [0:QUO_W-1];
    logic                take     [0:QUO_W-1];

    always_comb
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            take[k] = rem_reg[k] >= (WORK_W'(den_reg[k]) << (QUO_W - 1 - k));
            rem_next[k] = take[k] ? rem_reg[k] - (WORK_W'(den_reg[k]) << (QUO_W - 1 - k))
                                  : rem_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[QUO_W-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= WORK_W'(num_mag);
        den_reg[0]  <= den;
        quo_reg[0]  <= '0;
        neg_reg[0]  <= neg;
        side_reg[0] <= side_in;
        for (int k = 1; k < QUO_W; k++)
        begin
            rem_reg[k] <= rem_next[k-1];
            den_reg[k] <= den_reg[k-1];
        end
        for (int k = 1; k <= QUO_W; k++)
        begin
            quo_reg[k]  <= {quo_reg[k-1][QUO_W-2:0], take[k-1]};
            neg_reg[k]  <= neg_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign quo = neg_reg[QUO_W] ? -$signed({1'b0, quo_reg[QUO_W]})
                                : $signed({1'b0, quo_reg[QUO_W]});
    assign side_out = side_reg[QUO_W];

endmodule
`default_nettype wire

// ===== rtl/thermocouple_to_millicelsius.sv =====
// Top level: cold-junction compensated thermocouple conversion pipeline.
//
// Channel   | Handshake               | Payload
// request   | start, busy             | measured_microvolts, cold_junction_millidegrees
// result    | done                    | hot_junction_millidegrees, saturated
// config    | cfg_valid, cfg_ready    | thermocouple_type
//
// A new request is taken every cycle; busy stays low.
// Each request passes through stages a, b and c, the forward divider, stages e, f and g,
// the inverse divider and the done register; the dividers are bit-per-stage (20 and 26 stages).
// Reset clears the valid bits and sets the type to K.
// The result is shown for one cycle with done and cannot be stalled.
`default_nettype none
module thermocouple_to_millicelsius (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [17:0] measured_microvolts,
    input  wire logic signed [18:0] cold_junction_millidegrees,
    output logic                    done,
    output logic signed [21:0]      hot_junction_millidegrees,
    output logic                    saturated,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               thermocouple_type
);
    import tcc_pkg::*;

    localparam int LATENCY = 9 + FWD_QUO_W + INV_QUO_W;

    logic type_reg;

    logic                   a_valid_reg;
    logic signed [18:0]     a_cold_reg;
    logic signed [17:0]     a_uv_reg;
    logic                   a_type_reg;

    logic                   b_valid_reg;
    logic signed [21:0]     b_diff_reg;
    logic [12:0]            b_dy_reg;
    logic [16:0]            b_dx_reg;
    fwd_side_t              b_side_reg;
    logic [4:0]             b_seg;

    logic                   c_valid_reg;
    logic signed [35:0]     c_prod_reg;
    logic [16:0]            c_dx_reg;
    fwd_side_t              c_side_reg;
    logic signed [35:0]     b_prod;

    logic                   fd_valid;
    logic signed [FWD_QUO_W:0] fd_quo;
    fwd_side_t              fd_side;

    logic                   e_valid_reg;
    logic signed [22:0]     e_uv_reg;
    logic                   e_type_reg;

    logic                   f_valid_reg;
    logic signed [23:0]     f_diff_reg;
    logic [16:0]            f_dx_reg;
    logic [12:0]            f_dy_reg;
    inv_side_t              f_side_reg;
    logic [4:0]             f_seg;

    logic                   g_valid_reg;
    logic signed [41:0]     g_prod_reg;
    logic [12:0]            g_dy_reg;
    inv_side_t              g_side_reg;
    logic signed [41:0]     f_prod;

    logic                   id_valid;
    logic signed [INV_QUO_W:0] id_quo;
    inv_side_t              id_side;
    logic signed [27:0]     h_t;

    logic                   done_reg;
    logic signed [21:0]     hot_reg;
    logic                   sat_reg;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg    <= 1'b1;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                type_reg <= thermocouple_type;
            a_valid_reg <= start && !busy;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            e_valid_reg <= fd_valid;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            done_reg    <= id_valid;
        end
    end

    assign b_seg  = tcc_fwd_seg(a_type_reg, a_cold_reg);
    assign b_prod = b_diff_reg * $signed({1'b0, b_dy_reg});
    assign f_seg  = tcc_inv_seg(e_type_reg, e_uv_reg);
    assign f_prod = f_diff_reg * $signed({1'b0, f_dx_reg});
    assign h_t    = 28'(id_side.t1) + 28'(id_quo);

    always_ff @(posedge clk)
    begin
        a_cold_reg <= cold_junction_millidegrees;
        a_uv_reg   <= measured_microvolts;
        a_type_reg <= type_reg;

        b_diff_reg <= 22'(int'(a_cold_reg) - tcc_deg(a_type_reg, b_seg - 5'd1) * DEG_SCALE);
        b_dy_reg   <= 13'(tcc_uv(a_type_reg, b_seg) - tcc_uv(a_type_reg, b_seg - 5'd1));
        b_dx_reg   <= 17'((tcc_deg(a_type_reg, b_seg) - tcc_deg(a_type_reg, b_seg - 5'd1))
                          * DEG_SCALE);
        b_side_reg.y1     <= 17'(tcc_uv(a_type_reg, b_seg - 5'd1));
        b_side_reg.uv     <= a_uv_reg;
        b_side_reg.k_type <= a_type_reg;

        c_prod_reg <= b_prod;
        c_dx_reg   <= b_dx_reg;
        c_side_reg <= b_side_reg;

        e_uv_reg   <= 23'(fd_side.y1) + 23'(fd_quo) + 23'(fd_side.uv);
        e_type_reg <= fd_side.k_type;

        f_diff_reg <= 24'(int'(e_uv_reg) - tcc_uv(e_type_reg, f_seg - 5'd1));
        f_dx_reg   <= 17'((tcc_deg(e_type_reg, f_seg) - tcc_deg(e_type_reg, f_seg - 5'd1))
                          * DEG_SCALE);
        f_dy_reg   <= 13'(tcc_uv(e_type_reg, f_seg) - tcc_uv(e_type_reg, f_seg - 5'd1));
        f_side_reg.t1 <= 22'(tcc_deg(e_type_reg, f_seg - 5'd1) * DEG_SCALE);

        g_prod_reg <= f_prod;
        g_dy_reg   <= f_dy_reg;
        g_side_reg <= f_side_reg;

        if (int'(h_t) < OUT_MIN)
        begin
            hot_reg <= 22'(OUT_MIN);
            sat_reg <= 1'b1;
        end
        else if (int'(h_t) > OUT_MAX)
        begin
            hot_reg <= 22'(OUT_MAX);
            sat_reg <= 1'b1;
        end
        else
        begin
            hot_reg <= 22'(h_t);
            sat_reg <= 1'b0;
        end
    end

    tcc_div #(
        .NUM_W  (FWD_NUM_W),
        .DEN_W  (FWD_DEN_W),
        .QUO_W  (FWD_QUO_W),
        .SIDE_W ($bits(fwd_side_t))
    ) u_fwd_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .num_mag   (c_prod_reg[35] ? FWD_NUM_W'(-c_prod_reg) : FWD_NUM_W'(c_prod_reg)),
        .den       (c_dx_reg),
        .neg       (c_prod_reg[35]),
        .side_in   (c_side_reg),
        .out_valid (fd_valid),
        .quo       (fd_quo),
        .side_out  (fd_side)
    );

    tcc_div #(
        .NUM_W  (INV_NUM_W),
        .DEN_W  (INV_DEN_W),
        .QUO_W  (INV_QUO_W),
        .SIDE_W ($bits(inv_side_t))
    ) u_inv_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid_reg),
        .num_mag   (g_prod_reg[41] ? INV_NUM_W'(-g_prod_reg) : INV_NUM_W'(g_prod_reg)),
        .den       (g_dy_reg),
        .neg       (g_prod_reg[41]),
        .side_in   (g_side_reg),
        .out_valid (id_valid),
        .quo       (id_quo),
        .side_out  (id_side)
    );

    assign done = done_reg;
    assign hot_junction_millidegrees = hot_reg;
    assign saturated = sat_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result strobe missing after a request");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> hot_junction_millidegrees == 22'(OUT_MIN)
                           || hot_junction_millidegrees == 22'(OUT_MAX))
        else $error("saturated result not at a range limit");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> type_reg == $past(thermocouple_type))
        else $error("type register not updated by a write");

endmodule
`default_nettype wire
